### rtl/core/pal_pkg.sv
// Shared types and constants for the positional array list engine.
// Holds the command and result beat structs, action codes and the cell control bus.
// No dependencies.
package pal_pkg;

  localparam int PAL_CAPACITY = 16;
  localparam int CTL_IDX_W    = 9;

  localparam logic [2:0] ACT_INSERT  = 3'd0;
  localparam logic [2:0] ACT_DELETE  = 3'd1;
  localparam logic [2:0] ACT_GET     = 3'd2;
  localparam logic [2:0] ACT_FIND    = 3'd3;
  localparam logic [2:0] ACT_REVERSE = 3'd4;
  localparam logic [2:0] ACT_CLEAR   = 3'd5;

  typedef struct packed {
    logic [2:0]         action;
    logic [4:0]         position;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic               ok;
    logic [4:0]         found_index;
    logic signed [31:0] read_value;
    logic               prior_valid;
    logic signed [31:0] prior_value;
    logic               next_valid;
    logic signed [31:0] next_value;
    logic [4:0]         length_now;
  } rsp_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t               op;
    logic [CTL_IDX_W-1:0]   sel;
    logic [CTL_IDX_W-1:0]   lim;
    logic signed [31:0]     data;
  } cell_ctl_t;

endpackage

### rtl/core/positional_array_list_engine_unit.sv
// Positional array list engine: a chain of word cells under a small sequencer.
// Insert, delete, clear, unused codes and rejected actions return a beat in the cycle after start.
// Get and find rotate the n-entry prefix once, then the finish state gives the result beat.
// Reverse rotates shrinking prefixes in n-1 passes, then the finish state gives the result beat.
// For get, find and reverse, busy is high from the cycle after start until the result beat; the receiver cannot stall.
// Reset clears the entry count and control state; entry storage is not cleared.
module positional_array_list_engine_unit #(
  parameter int CAPACITY = pal_pkg::PAL_CAPACITY
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  pal_pkg::cmd_t cmd,
  output logic          busy,
  output logic          strobe,
  output pal_pkg::rsp_t result
);
  import pal_pkg::*;

  cell_ctl_t          ctl;
  logic signed [31:0] cell_q [CAPACITY];

  pal_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .head  (cell_q[0]),
    .busy  (busy),
    .strobe(strobe),
    .rsp   (result),
    .ctl   (ctl)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_d;
    logic signed [31:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_inner_l
      assign left_d = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner_r
      assign right_d = cell_q[i+1];
    end

    pal_cell #(
      .INDEX(i)
    ) u_cell (
      .clk  (clk),
      .ctl  (ctl),
      .left (left_d),
      .right(right_d),
      .head (cell_q[0]),
      .q    (cell_q[i])
    );
  end

endmodule

### rtl/core/pal_cell.sv
// One storage cell of the list chain, holding a single 32-bit entry.
// Takes its neighbor's word, the new word or the head word as the control bus selects.
// Depends on pal_pkg.
module pal_cell #(
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  pal_pkg::cell_ctl_t ctl,
  input  logic signed [31:0] left,
  input  logic signed [31:0] right,
  input  logic signed [31:0] head,
  output logic signed [31:0] q
);
  import pal_pkg::*;

  localparam logic [CTL_IDX_W-1:0] IDX = CTL_IDX_W'(INDEX);
  localparam logic [CTL_IDX_W-1:0] IDX_UP = CTL_IDX_W'(INDEX + 1);

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_INSERT: begin
        if (IDX == ctl.sel) begin
          q <= ctl.data;
        end else if (IDX > ctl.sel && IDX <= ctl.lim) begin
          q <= left;
        end
      end
      CELL_DELETE: begin
        if (IDX >= ctl.sel && IDX_UP < ctl.lim) begin
          q <= right;
        end
      end
      CELL_ROTATE: begin
        if (IDX_UP < ctl.lim) begin
          q <= right;
        end else if (IDX_UP == ctl.lim) begin
          q <= head;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/pal_ctrl.sv
// Sequencer of the list engine: decodes commands, keeps the entry count,
// drives the cell chain and builds result beats. Depends on pal_pkg.
module pal_ctrl #(
  parameter int CAPACITY = pal_pkg::PAL_CAPACITY
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  pal_pkg::cmd_t      cmd,
  input  logic signed [31:0] head,
  output logic               busy,
  output logic               strobe,
  output pal_pkg::rsp_t      rsp,
  output pal_pkg::cell_ctl_t ctl
);
  import pal_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CTL_IDX_W-1:0] CAP_X = CTL_IDX_W'(CAPACITY);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_REV, S_FIN} state_t;

  state_t                 state;
  logic [CW-1:0]          count;
  logic [CW-1:0]          span;
  logic [CW-1:0]          step;
  logic [2:0]             op_q;
  logic [CTL_IDX_W-1:0]   pos_idx;
  logic signed [31:0]     val_q;
  logic                   hit;
  logic [CW-1:0]          fidx;
  logic signed [31:0]     rd;
  logic                   pv;
  logic signed [31:0]     pval;
  logic                   nv;
  logic signed [31:0]     nval;
  logic signed [31:0]     prev;

  logic                   accept;
  logic [CTL_IDX_W-1:0]   pos_x;
  logic [CTL_IDX_W-1:0]   cnt_x;
  logic                   ins_ok;
  logic                   del_ok;
  logic                   last_step;

  assign accept    = start && !busy;
  assign pos_x     = CTL_IDX_W'(cmd.position);
  assign cnt_x     = CTL_IDX_W'(count);
  assign ins_ok    = (pos_x != '0) && (pos_x <= cnt_x + CTL_IDX_W'(1)) && (cnt_x < CAP_X);
  assign del_ok    = (pos_x != '0) && (pos_x <= cnt_x);
  assign last_step = ((step + CW'(1)) == span);

  always_comb begin
    ctl      = '0;
    ctl.op   = CELL_HOLD;
    ctl.sel  = pos_x - CTL_IDX_W'(1);
    ctl.lim  = cnt_x;
    ctl.data = cmd.value;
    unique case (state)
      S_IDLE: begin
        if (accept && cmd.action == ACT_INSERT && ins_ok) begin
          ctl.op = CELL_INSERT;
        end else if (accept && cmd.action == ACT_DELETE && del_ok) begin
          ctl.op = CELL_DELETE;
        end
      end
      S_SCAN, S_REV: begin
        ctl.op  = CELL_ROTATE;
        ctl.lim = CTL_IDX_W'(span);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      busy   <= 1'b0;
      strobe <= 1'b0;
      count  <= '0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            rsp            <= '0;
            rsp.length_now <= 5'(count);
            strobe         <= 1'b1;
            op_q           <= cmd.action;
            pos_idx        <= pos_x - CTL_IDX_W'(1);
            val_q          <= cmd.value;
            span           <= count;
            step           <= '0;
            hit            <= 1'b0;
            fidx           <= '0;
            rd             <= '0;
            pv             <= 1'b0;
            pval           <= '0;
            nv             <= 1'b0;
            nval           <= '0;
            prev           <= '0;
            unique case (cmd.action)
              ACT_INSERT: begin
                if (ins_ok) begin
                  count          <= count + CW'(1);
                  rsp.ok         <= 1'b1;
                  rsp.length_now <= 5'(count + CW'(1));
                end
              end
              ACT_DELETE: begin
                if (del_ok) begin
                  count          <= count - CW'(1);
                  rsp.ok         <= 1'b1;
                  rsp.length_now <= 5'(count - CW'(1));
                end
              end
              ACT_GET: begin
                if (del_ok) begin
                  strobe <= 1'b0;
                  busy   <= 1'b1;
                  state  <= S_SCAN;
                end
              end
              ACT_FIND: begin
                if (count != '0) begin
                  strobe <= 1'b0;
                  busy   <= 1'b1;
                  state  <= S_SCAN;
                end
              end
              ACT_REVERSE: begin
                if (count >= CW'(2)) begin
                  strobe <= 1'b0;
                  busy   <= 1'b1;
                  state  <= S_REV;
                end
              end
              ACT_CLEAR: begin
                count          <= '0;
                rsp.length_now <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          step <= step + CW'(1);
          prev <= head;
          if (op_q == ACT_GET) begin
            if (pos_idx == CTL_IDX_W'(step)) begin
              hit <= 1'b1;
              rd  <= head;
            end
          end else if (!hit && head == val_q) begin
            hit  <= 1'b1;
            fidx <= step + CW'(1);
            pv   <= (step != '0);
            pval <= (step != '0) ? prev : '0;
            nv   <= 1'b0;
            nval <= '0;
          end else if (step == '0 || (hit && step == fidx)) begin
            nv   <= 1'b1;
            nval <= head;
          end
          if (last_step) begin
            state <= S_FIN;
          end
        end
        S_REV: begin
          span <= span - CW'(1);
          if (span == CW'(2)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          strobe          <= 1'b1;
          busy            <= 1'b0;
          state           <= S_IDLE;
          rsp.ok          <= hit;
          rsp.found_index <= 5'(fidx);
          rsp.read_value  <= rd;
          rsp.prior_valid <= pv;
          rsp.prior_value <= pval;
          rsp.next_valid  <= nv;
          rsp.next_value  <= nval;
          rsp.length_now  <= 5'(count);
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_strobe_idle: assert property (@(posedge clk) disable iff (rst) strobe |-> !busy)
    else $error("result beat issued while busy");
  a_count_cap: assert property (@(posedge clk) disable iff (rst) count <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");
  a_insert_beat: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.action == ACT_INSERT) |=> strobe)
    else $error("insert did not return a beat in the next cycle");
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (strobe && rsp.found_index != '0) |-> rsp.ok)
    else $error("match index reported without ok");

endmodule
